### rtl/core/alsc_pkg.sv
// alsc_pkg: shared types and constants of the local alignment scorer
// no dependencies; used by the interfaces and every rtl/core module
`default_nettype none

package alsc_pkg;

  localparam int SYM_W       = 2;
  localparam int SCORE_W     = 8;
  localparam int CALC_W      = 10;
  localparam int PEN_W       = 4;
  localparam int QLEN_W      = 5;
  localparam int QSYM_W      = 32;
  localparam int QSYM_COUNT  = 16;
  localparam int REF_POS_W   = 14;
  localparam int QRY_POS_W   = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 8'd255;

  // register reset values
  localparam logic [QSYM_W-1:0] QSYM_RESET     = 32'd0;
  localparam logic [QLEN_W-1:0] QLEN_RESET     = 5'd11;
  localparam logic [PEN_W-1:0]  MATCH_RESET    = 4'd3;
  localparam logic [PEN_W-1:0]  MISMATCH_RESET = 4'd3;
  localparam logic [PEN_W-1:0]  GAP_RESET      = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_SYMBOLS    = 3'd0,
    REG_QUERY_LENGTH     = 3'd1,
    REG_MATCH_SCORE      = 3'd2,
    REG_MISMATCH_PENALTY = 3'd3,
    REG_GAP_PENALTY      = 3'd4
  } reg_index_t;

  // scoring settings shared by all cells
  typedef struct packed {
    logic [PEN_W-1:0] match;
    logic [PEN_W-1:0] mismatch;
    logic [PEN_W-1:0] gap;
  } score_cfg_t;

  // wavefront token handed from one cell to the next
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [SYM_W-1:0]   ref_symbol;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] col_best;
  } token_t;

endpackage

`default_nettype wire

### rtl/core/alsc_in_if.sv
// alsc_in_if: valid/ready channel carrying one reference symbol
// depends on alsc_pkg
`default_nettype none

interface alsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [alsc_pkg::SYM_W-1:0]  ref_symbol;
  logic                        last_symbol;

  modport source (output valid, ref_symbol, last_symbol, input ready);
  modport sink (input valid, ref_symbol, last_symbol, output ready);
endinterface

`default_nettype wire

### rtl/core/alsc_out_if.sv
// alsc_out_if: valid/ready channel carrying one running-best result
// depends on alsc_pkg
`default_nettype none

interface alsc_out_if;
  logic                            valid;
  logic                            ready;
  logic [alsc_pkg::SCORE_W-1:0]    best_score;
  logic [alsc_pkg::REF_POS_W-1:0]  best_ref_position;
  logic [alsc_pkg::QRY_POS_W-1:0]  best_query_position;
  logic                            is_last;

  modport source (output valid, best_score, best_ref_position, best_query_position, is_last,
                  input ready);
  modport sink (input valid, best_score, best_ref_position, best_query_position, is_last,
                output ready);
endinterface

`default_nettype wire

### rtl/core/local_alignment_scorer_top.sv
// local_alignment_scorer_top: top level of the local alignment scorer
// depends on alsc_pkg, alsc_in_if, alsc_out_if, alsc_cell and alsc_track
// Smith-Waterman local alignment scorer with a linear gap penalty. The query
// (up to QUERY_MAX two-bit nucleotides) and the scores sit in configuration
// registers; reference symbols arrive one per transfer and each gives one
// result transfer with the running best score, its reference column and its
// query row. A row of QUERY_MAX cells, one per query row, each holds its own
// column score; a token for each reference symbol walks down the row one cell
// per cycle carrying the diagonal and upper scores and the column's best so
// far, so a new symbol is taken every cycle unless the result side stalls;
// the result passes through every cell and then the result register. A
// stall on the result side holds the whole chain. After the symbol marked
// last the scores and the best cell clear. Configuration must be written
// only while the chain is empty; the block itself does not enforce this.
`default_nettype none

module local_alignment_scorer_top #(
  parameter int QUERY_MAX = 16,
  parameter int REF_MAX   = 16383
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [alsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [alsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  alsc_in_if.sink                                item_in,
  alsc_out_if.source                             result_out
);

  localparam int RW = $clog2(QUERY_MAX + 1);

  // configuration registers
  logic [alsc_pkg::QSYM_W-1:0] query_symbols;
  logic [alsc_pkg::QLEN_W-1:0] query_length;
  alsc_pkg::score_cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_symbols <= alsc_pkg::QSYM_RESET;
      query_length  <= alsc_pkg::QLEN_RESET;
      cfg.match     <= alsc_pkg::MATCH_RESET;
      cfg.mismatch  <= alsc_pkg::MISMATCH_RESET;
      cfg.gap       <= alsc_pkg::GAP_RESET;
    end else if (cfg_write) begin
      case (alsc_pkg::reg_index_t'(cfg_index))
        alsc_pkg::REG_QUERY_SYMBOLS:    query_symbols <= cfg_data;
        alsc_pkg::REG_QUERY_LENGTH:     query_length  <= cfg_data[alsc_pkg::QLEN_W-1:0];
        alsc_pkg::REG_MATCH_SCORE:      cfg.match     <= cfg_data[alsc_pkg::PEN_W-1:0];
        alsc_pkg::REG_MISMATCH_PENALTY: cfg.mismatch  <= cfg_data[alsc_pkg::PEN_W-1:0];
        alsc_pkg::REG_GAP_PENALTY:      cfg.gap       <= cfg_data[alsc_pkg::PEN_W-1:0];
        default: ;
      endcase
    end
  end

  // whole chain advances together unless a finished result is held
  logic advance;
  assign advance       = !result_out.valid || result_out.ready;
  assign item_in.ready = advance;

  alsc_pkg::token_t tok [0:QUERY_MAX];
  logic [RW-1:0]    row [0:QUERY_MAX];

  // row zero above the first cell: diagonal and upper scores are zero
  always_comb begin
    tok[0].valid      = item_in.valid;
    tok[0].last       = item_in.last_symbol;
    tok[0].ref_symbol = item_in.ref_symbol;
    tok[0].diag       = '0;
    tok[0].up         = '0;
    tok[0].col_best   = '0;
    row[0]            = '0;
  end

  for (genvar g = 0; g < QUERY_MAX; g++) begin : g_cell
    logic [alsc_pkg::SYM_W-1:0] qsym;
    logic                       active;

    // query symbols past the register width read as code zero
    if (g < alsc_pkg::QSYM_COUNT) begin : g_sym
      assign qsym = query_symbols[alsc_pkg::SYM_W*g +: alsc_pkg::SYM_W];
    end else begin : g_nosym
      assign qsym = '0;
    end

    // rows at or past the query length are held at zero
    assign active = (query_length > alsc_pkg::QLEN_W'(g));

    alsc_cell #(
      .ROW (g),
      .RW  (RW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .active    (active),
      .query_sym (qsym),
      .cfg       (cfg),
      .tok_in    (tok[g]),
      .row_in    (row[g]),
      .tok_out   (tok[g+1]),
      .row_out   (row[g+1])
    );
  end

  alsc_track #(
    .QUERY_MAX (QUERY_MAX),
    .REF_MAX   (REF_MAX),
    .RW        (RW)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .tok_in     (tok[QUERY_MAX]),
    .row_in     (row[QUERY_MAX]),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

### rtl/core/alsc_cell.sv
// alsc_cell: one query row of the systolic scoring chain
// depends on alsc_pkg
`default_nettype none

module alsc_cell #(
  parameter int ROW = 0,
  parameter int RW  = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          active,
  input  wire logic [alsc_pkg::SYM_W-1:0]    query_sym,
  input  wire alsc_pkg::score_cfg_t          cfg,
  input  wire alsc_pkg::token_t              tok_in,
  input  wire logic [RW-1:0]                 row_in,
  output alsc_pkg::token_t                   tok_out,
  output logic [RW-1:0]                      row_out
);

  logic [alsc_pkg::SCORE_W-1:0] score;
  logic signed [alsc_pkg::CALC_W-1:0] diag_term, left_term, up_term, best_term;
  logic [alsc_pkg::SCORE_W-1:0] cell_val;
  logic [alsc_pkg::SCORE_W-1:0] up_val;
  logic                         new_best;

  always_comb begin
    if (query_sym == tok_in.ref_symbol) begin
      diag_term = signed'(alsc_pkg::CALC_W'(tok_in.diag)) + signed'(alsc_pkg::CALC_W'(cfg.match));
    end else begin
      diag_term = signed'(alsc_pkg::CALC_W'(tok_in.diag))
                - signed'(alsc_pkg::CALC_W'(cfg.mismatch));
    end
    left_term = signed'(alsc_pkg::CALC_W'(score)) - signed'(alsc_pkg::CALC_W'(cfg.gap));
    up_term   = signed'(alsc_pkg::CALC_W'(tok_in.up)) - signed'(alsc_pkg::CALC_W'(cfg.gap));
    best_term = diag_term;
    if (left_term > best_term) begin
      best_term = left_term;
    end
    if (up_term > best_term) begin
      best_term = up_term;
    end
    // floor at zero, saturate at the top
    if (best_term < 0) begin
      cell_val = '0;
    end else if (best_term > signed'(alsc_pkg::CALC_W'(alsc_pkg::SCORE_MAX))) begin
      cell_val = alsc_pkg::SCORE_MAX;
    end else begin
      cell_val = best_term[alsc_pkg::SCORE_W-1:0];
    end
    up_val   = active ? cell_val : '0;
    new_best = active && (cell_val > tok_in.col_best);
  end

  // column score held by this row; cleared after the last symbol
  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
    end else if (en && tok_in.valid) begin
      score <= tok_in.last ? '0 : up_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_out.last       <= tok_in.last;
      tok_out.ref_symbol <= tok_in.ref_symbol;
      tok_out.diag       <= score;
      tok_out.up         <= up_val;
      if (new_best) begin
        tok_out.col_best <= cell_val;
        row_out          <= RW'(ROW + 1);
      end else begin
        tok_out.col_best <= tok_in.col_best;
        row_out          <= row_in;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/alsc_track.sv
// alsc_track: running best across columns, column counter and result register
// depends on alsc_pkg and alsc_out_if
`default_nettype none

module alsc_track #(
  parameter int QUERY_MAX = 16,
  parameter int REF_MAX   = 16383,
  parameter int RW        = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire alsc_pkg::token_t  tok_in,
  input  wire logic [RW-1:0]     row_in,
  alsc_out_if.source             result_out
);

  localparam int CW = $clog2(REF_MAX + 1);

  logic [CW-1:0]                column_count, column_count_next;
  logic [alsc_pkg::SCORE_W-1:0] best, best_next;
  logic [CW-1:0]                best_col, best_col_next;
  logic [RW-1:0]                best_row, best_row_next;
  logic                         out_valid;
  logic [alsc_pkg::SCORE_W-1:0] out_score;
  logic [CW-1:0]                out_col;
  logic [RW-1:0]                out_row;
  logic                         out_last;

  always_comb begin
    column_count_next = (column_count < CW'(REF_MAX)) ? column_count + 1'b1 : column_count;
    // strictly greater keeps the earlier column on a tie
    if (tok_in.col_best > best) begin
      best_next     = tok_in.col_best;
      best_col_next = column_count_next;
      best_row_next = row_in;
    end else begin
      best_next     = best;
      best_col_next = best_col;
      best_row_next = best_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      best         <= '0;
      best_col     <= '0;
      best_row     <= '0;
    end else if (en && tok_in.valid) begin
      if (tok_in.last) begin
        column_count <= '0;
        best         <= '0;
        best_col     <= '0;
        best_row     <= '0;
      end else begin
        column_count <= column_count_next;
        best         <= best_next;
        best_col     <= best_col_next;
        best_row     <= best_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tok_in.valid) begin
      out_score <= best_next;
      out_col   <= best_col_next;
      out_row   <= best_row_next;
      out_last  <= tok_in.last;
    end
  end

  assign result_out.valid               = out_valid;
  assign result_out.best_score          = out_score;
  assign result_out.best_ref_position   = alsc_pkg::REF_POS_W'(out_col);
  assign result_out.best_query_position = alsc_pkg::QRY_POS_W'(out_row);
  assign result_out.is_last             = out_last;

  a_zero_best_no_cell : assert property (@(posedge clk) disable iff (rst)
    (best == '0) |-> (best_col == '0 && best_row == '0))
    else $error("best cell recorded without a score");

  a_row_in_range : assert property (@(posedge clk) disable iff (rst)
    best_row <= RW'(QUERY_MAX))
    else $error("best row beyond the query");

  a_col_in_range : assert property (@(posedge clk) disable iff (rst)
    (column_count <= CW'(REF_MAX)) && (best_col <= column_count))
    else $error("best column ahead of column counter");

  a_clear_after_last : assert property (@(posedge clk) disable iff (rst)
    (en && tok_in.valid && tok_in.last) |=> (best == '0 && column_count == '0))
    else $error("state not cleared after last symbol");

endmodule

`default_nettype wire
